// ===== rtl/core/mcst_pkg.sv =====
// ----------------------------------------------------------------------------
// mcst_pkg: shared types for the moving circle sweep test
// Status flags that ride along the pipeline with each pair of circles.
// ----------------------------------------------------------------------------
package mcst_pkg;

	// partial product slice width of the wide multipliers
	localparam int MulChunk = 16;

	typedef struct packed {
		logic overlap;   // circles already touch at the start
		logic still;     // no relative motion
		logic disc_neg;  // no real contact times
	} mcst_flags_t;

endpackage

// ===== rtl/core/moving_circle_sweep_test.sv =====
// ----------------------------------------------------------------------------
// moving_circle_sweep_test: swept circle pair contact test
// Gives hit and both contact times for two circles moving over one frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pair of circles per word (start, end, radius of each),
//   m_axis returns one word per pair: hit and the two contact times in
//   ascending order, signed fixed point, saturated. Times are zero on a miss
//   and when the circles already overlap at the start.
//   One word is taken every cycle unless the output stalls (see below). The
//   square root stages (one root bit per stage) and the divider stages (one
//   quotient bit per stage) make up most of the pipeline.
//   The whole pipeline advances together: while a result sits in the output
//   register and m_axis_tready is low, s_axis_tready is low and every stage
//   holds. Nothing is dropped or repeated.
//   Reset clears all valid bits; the block takes words right after reset.
// ----------------------------------------------------------------------------
module moving_circle_sweep_test
	import mcst_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y, first_radius,
	// second_start_x, second_start_y, second_end_x, second_end_y, second_radius
	input  logic [((10*COORD_WIDTH+5)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit, time_first, time_second
	output logic [((2*COORD_WIDTH+8)/8)*8-1:0]  m_axis_tdata
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int MW  = 2 * CW + 5;
	localparam int SIW = 2 * MW + 2 * F;
	localparam int SQW = MW + F;
	localparam int NW  = MW + F + 2;
	localparam int FLW = $bits(mcst_flags_t);
	localparam int OW  = ((2 * CW + 8) / 8) * 8;

	logic en;

	logic signed [CW-1:0] fsx, fsy, fex, fey, ssx, ssy, sex, sey;
	logic [CW-2:0]        fr, sr;

	assign fsx = s_axis_tdata[0*CW +: CW];
	assign fsy = s_axis_tdata[1*CW +: CW];
	assign fex = s_axis_tdata[2*CW +: CW];
	assign fey = s_axis_tdata[3*CW +: CW];
	assign fr  = s_axis_tdata[4*CW +: CW-1];
	assign ssx = s_axis_tdata[5*CW-1 +: CW];
	assign ssy = s_axis_tdata[6*CW-1 +: CW];
	assign sex = s_axis_tdata[7*CW-1 +: CW];
	assign sey = s_axis_tdata[8*CW-1 +: CW];
	assign sr  = s_axis_tdata[9*CW-1 +: CW-1];

	// coefficients
	logic          f_valid, f_qhn;
	logic [MW-1:0] f_qa, f_qh, f_qc;
	mcst_flags_t   f_flags;

	mcst_front #(.CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.fsx      (fsx),
		.fsy      (fsy),
		.fex      (fex),
		.fey      (fey),
		.fr       (fr),
		.ssx      (ssx),
		.ssy      (ssy),
		.sex      (sex),
		.sey      (sey),
		.sr       (sr),
		.out_valid(f_valid),
		.qa_mag   (f_qa),
		.qh_mag   (f_qh),
		.qh_neg   (f_qhn),
		.qc_raw   (f_qc),
		.flags    (f_flags)
	);

	// discriminant qh^2 - qa*qc
	localparam int DSB = FLW + 1 + 2 * MW;
	logic                 d_valid, d_qhn;
	logic signed [2*MW:0] d_disc;
	logic [DSB-1:0]       d_sb;
	logic [MW-1:0]        d_qa, d_qh;
	mcst_flags_t          d_flags;

	mcst_disc #(.MW(MW), .SBW(DSB)) u_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.a        (f_qh),
		.b        (f_qh),
		.c        (f_qa),
		.d        (f_qc),
		.sb_in    ({f_flags, f_qhn, f_qh, f_qa}),
		.out_valid(d_valid),
		.disc     (d_disc),
		.sb_out   (d_sb)
	);

	assign {d_flags, d_qhn, d_qh, d_qa} = d_sb;

	// scale for the root, form -qh in time units
	logic                 v_s1, v_s2;
	logic [SIW-1:0]       rad_s1;
	logic signed [NW-1:0] base_s1;
	logic [MW-1:0]        qa_s1, qa_s2;
	mcst_flags_t          fl_s1, fl_s2;
	logic signed [NW-1:0] nlo_s2, nhi_s2;

	localparam int RSB = FLW + NW + MW;
	logic                 r_valid;
	logic [SQW-1:0]       r_root;
	logic [RSB-1:0]       r_sb;
	logic signed [NW-1:0] r_base;
	logic [MW-1:0]        r_qa;
	mcst_flags_t          r_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_valid;
			v_s2 <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1          <= '{overlap: d_flags.overlap, still: d_flags.still,
				disc_neg: d_disc[2*MW]};
			rad_s1         <= d_disc[2*MW] ? '0 : {d_disc[2*MW-1:0], {(2*F){1'b0}}};
			base_s1        <= d_qhn ? (NW'(d_qh) << F) : -(NW'(d_qh) << F);
			qa_s1          <= d_qa;

			fl_s2  <= r_flags;
			qa_s2  <= r_qa;
			nlo_s2 <= r_base - $signed(NW'(r_root));
			nhi_s2 <= r_base + $signed(NW'(r_root));
		end
	end

	// root of the scaled discriminant
	mcst_sqrt #(.IW(SIW), .SBW(RSB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.rad      (rad_s1),
		.sb_in    ({fl_s1, base_s1, qa_s1}),
		.out_valid(r_valid),
		.root     (r_root),
		.sb_out   (r_sb)
	);

	assign {r_flags, r_base, r_qa} = r_sb;

	// contact times
	logic                 q_valid;
	logic signed [CW-1:0] q_lo, q_hi;
	mcst_flags_t          q_flags;

	mcst_div #(.NW(NW), .DW(MW), .CW(CW), .SBW(FLW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num_lo   (nlo_s2),
		.num_hi   (nhi_s2),
		.den      (qa_s2),
		.sb_in    (fl_s2),
		.out_valid(q_valid),
		.t_lo     (q_lo),
		.t_hi     (q_hi),
		.sb_out   (q_flags)
	);

	// output word register
	logic          m_valid_q, hit_q;
	logic [CW-1:0] tf_q, ts_q;
	logic          hit, show;

	assign hit  = q_flags.overlap | (~q_flags.still & ~q_flags.disc_neg);
	assign show = hit & ~q_flags.overlap;
	assign en   = ~m_valid_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit;
			tf_q  <= show ? q_lo : '0;
			ts_q  <= show ? q_hi : '0;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OW'({ts_q, tf_q, hit_q});

endmodule

// ===== rtl/core/mcst_front.sv =====
// ----------------------------------------------------------------------------
// mcst_front: relative motion and quadratic coefficients
// Four stages: differences, products, sums, magnitudes and flags.
// ----------------------------------------------------------------------------
module mcst_front
	import mcst_pkg::*;
#(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] fsx,
	input  logic signed [CW-1:0] fsy,
	input  logic signed [CW-1:0] fex,
	input  logic signed [CW-1:0] fey,
	input  logic [CW-2:0]        fr,
	input  logic signed [CW-1:0] ssx,
	input  logic signed [CW-1:0] ssy,
	input  logic signed [CW-1:0] sex,
	input  logic signed [CW-1:0] sey,
	input  logic [CW-2:0]        sr,
	output logic                 out_valid,
	output logic [2*CW+4:0]      qa_mag,
	output logic [2*CW+4:0]      qh_mag,
	output logic                 qh_neg,
	output logic [2*CW+4:0]      qc_raw,
	output mcst_flags_t          flags
);

	localparam int VW = CW + 2;
	localparam int PW = CW + 1;
	localparam int RW = CW;
	localparam int MW = 2 * CW + 5;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [VW-1:0]   vx_s1, vy_s1;
	logic signed [PW-1:0]   px_s1, py_s1;
	logic [RW-1:0]          rs_s1;
	logic signed [2*VW-1:0] vxx_s2, vyy_s2;
	logic signed [VW+PW-1:0] vxp_s2, vyp_s2;
	logic signed [2*PW-1:0] pxx_s2, pyy_s2;
	logic [2*RW-1:0]        rss_s2;
	logic signed [MW-1:0]   qa_s3, qh_s3, qc_s3;
	logic [MW-1:0]          qa_s4, qh_s4, qc_s4;
	logic                   qhn_s4;
	mcst_flags_t            fl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1  <= VW'(sex) - VW'(ssx) - VW'(fex) + VW'(fsx);
			vy_s1  <= VW'(sey) - VW'(ssy) - VW'(fey) + VW'(fsy);
			px_s1  <= PW'(ssx) - PW'(fsx);
			py_s1  <= PW'(ssy) - PW'(fsy);
			rs_s1  <= RW'(fr) + RW'(sr);

			vxx_s2 <= vx_s1 * vx_s1;
			vyy_s2 <= vy_s1 * vy_s1;
			vxp_s2 <= vx_s1 * px_s1;
			vyp_s2 <= vy_s1 * py_s1;
			pxx_s2 <= px_s1 * px_s1;
			pyy_s2 <= py_s1 * py_s1;
			rss_s2 <= rs_s1 * rs_s1;

			qa_s3  <= MW'(vxx_s2) + MW'(vyy_s2);
			qh_s3  <= MW'(vxp_s2) + MW'(vyp_s2);
			qc_s3  <= MW'(pxx_s2) + MW'(pyy_s2)
				- $signed({{(MW-2*RW){1'b0}}, rss_s2});

			qa_s4  <= qa_s3;
			qhn_s4 <= qh_s3[MW-1];
			qh_s4  <= qh_s3[MW-1] ? MW'(-qh_s3) : qh_s3;
			qc_s4  <= qc_s3;
			fl_s4  <= '{overlap: qc_s3[MW-1] | (qc_s3 == '0),
				still: (qa_s3 == '0), disc_neg: 1'b0};
		end
	end

	assign out_valid = v_s4;
	assign qa_mag    = qa_s4;
	assign qh_mag    = qh_s4;
	assign qh_neg    = qhn_s4;
	assign qc_raw    = qc_s4;
	assign flags     = fl_s4;

endmodule

// ===== rtl/core/mcst_disc.sv =====
// ----------------------------------------------------------------------------
// mcst_disc: pipelined discriminant a*b - c*d
// One slice of b and d per stage, accumulated into a signed sum.
// ----------------------------------------------------------------------------
module mcst_disc
	import mcst_pkg::*;
#(
	parameter int MW  = 69,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [MW-1:0]        a,
	input  logic [MW-1:0]        b,
	input  logic [MW-1:0]        c,
	input  logic [MW-1:0]        d,
	input  logic [SBW-1:0]       sb_in,
	output logic                 out_valid,
	output logic signed [2*MW:0] disc,
	output logic [SBW-1:0]       sb_out
);

	localparam int NCH = (MW + MulChunk - 1) / MulChunk;
	localparam int BPW = NCH * MulChunk;
	localparam int AW  = 2 * MW + 1;

	logic           v_s   [1:NCH];
	logic [MW-1:0]  a_s   [1:NCH];
	logic [MW-1:0]  c_s   [1:NCH];
	logic [BPW-1:0] b_s   [1:NCH];
	logic [BPW-1:0] d_s   [1:NCH];
	logic [AW-1:0]  acc_s [1:NCH];
	logic [SBW-1:0] sb_s  [1:NCH];

	for (genvar k = 0; k < NCH; k++) begin : g_stage
		logic [MW-1:0]          a_cur, c_cur;
		logic [BPW-1:0]         b_cur, d_cur;
		logic [AW-1:0]          acc_cur;
		logic [SBW-1:0]         sb_cur;
		logic                   v_cur;
		logic [MW+MulChunk-1:0] pp_ab, pp_cd;

		if (k == 0) begin : g_head
			assign a_cur   = a;
			assign c_cur   = c;
			assign b_cur   = BPW'(b);
			assign d_cur   = BPW'(d);
			assign acc_cur = '0;
			assign sb_cur  = sb_in;
			assign v_cur   = in_valid;
		end else begin : g_body
			assign a_cur   = a_s[k];
			assign c_cur   = c_s[k];
			assign b_cur   = b_s[k];
			assign d_cur   = d_s[k];
			assign acc_cur = acc_s[k];
			assign sb_cur  = sb_s[k];
			assign v_cur   = v_s[k];
		end

		assign pp_ab = a_cur * b_cur[k*MulChunk +: MulChunk];
		assign pp_cd = c_cur * d_cur[k*MulChunk +: MulChunk];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k+1]   <= a_cur;
				c_s[k+1]   <= c_cur;
				b_s[k+1]   <= b_cur;
				d_s[k+1]   <= d_cur;
				sb_s[k+1]  <= sb_cur;
				acc_s[k+1] <= acc_cur + (AW'(pp_ab) << (MulChunk * k))
					- (AW'(pp_cd) << (MulChunk * k));
			end
		end
	end

	assign out_valid = v_s[NCH];
	assign disc      = $signed(acc_s[NCH]);
	assign sb_out    = sb_s[NCH];

endmodule

// ===== rtl/core/mcst_sqrt.sv =====
// ----------------------------------------------------------------------------
// mcst_sqrt: pipelined floor square root
// Restoring method, one root bit per stage.
// ----------------------------------------------------------------------------
module mcst_sqrt #(
	parameter int IW  = 170,
	parameter int SBW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IW-1:0]     rad,
	input  logic [SBW-1:0]    sb_in,
	output logic              out_valid,
	output logic [IW/2-1:0]   root,
	output logic [SBW-1:0]    sb_out
);

	localparam int NS = IW / 2;

	logic           v_s  [1:NS];
	logic [IW-1:0]  n_s  [1:NS];
	logic [IW-1:0]  r_s  [1:NS];
	logic [SBW-1:0] sb_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic [IW-1:0] Bit = IW'(1) << (IW - 2 - 2 * k);
		logic [IW-1:0]  n_cur, r_cur, t;
		logic [SBW-1:0] sb_cur;
		logic           v_cur;

		if (k == 0) begin : g_head
			assign n_cur  = rad;
			assign r_cur  = '0;
			assign sb_cur = sb_in;
			assign v_cur  = in_valid;
		end else begin : g_body
			assign n_cur  = n_s[k];
			assign r_cur  = r_s[k];
			assign sb_cur = sb_s[k];
			assign v_cur  = v_s[k];
		end

		assign t = r_cur + Bit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_cur;
				if (n_cur >= t) begin
					n_s[k+1] <= n_cur - t;
					r_s[k+1] <= (r_cur >> 1) + Bit;
				end else begin
					n_s[k+1] <= n_cur;
					r_s[k+1] <= r_cur >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[NS];
	assign root      = r_s[NS][IW/2-1:0];
	assign sb_out    = sb_s[NS];

endmodule

// ===== rtl/core/mcst_div.sv =====
// ----------------------------------------------------------------------------
// mcst_div: dual floor divider with saturation
// Two signed numerators over one positive divisor; one quotient bit per
// stage, range check up front, saturated to CW signed bits at the end.
// ----------------------------------------------------------------------------
module mcst_div #(
	parameter int NW  = 88,
	parameter int DW  = 69,
	parameter int CW  = 32,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num_lo,
	input  logic signed [NW-1:0] num_hi,
	input  logic [DW-1:0]        den,
	input  logic [SBW-1:0]       sb_in,
	output logic                 out_valid,
	output logic signed [CW-1:0] t_lo,
	output logic signed [CW-1:0] t_hi,
	output logic [SBW-1:0]       sb_out
);

	localparam int XW  = ((NW > DW) ? NW : DW) + 1;
	localparam int RWD = (XW > DW + CW) ? XW : DW + CW;
	localparam logic [CW-1:0] MaxT = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MinT = {1'b1, {(CW-1){1'b0}}};

	logic           v_s1, v_s2, v_sn;
	logic           neg_s1 [2];
	logic [NW-1:0]  mag_s1 [2];
	logic [DW-1:0]  den_s1, den_s2;
	logic [SBW-1:0] sb_s1, sb_s2, sb_sn;
	logic           neg_s2 [2];
	logic [XW-1:0]  dvd_s2 [2];

	// quotient stages, index 0 holds the range check
	logic           v_s   [CW+1];
	logic           neg_s [CW+1][2];
	logic           ovf_s [CW+1][2];
	logic [RWD-1:0] rem_s [CW+1][2];
	logic [CW-1:0]  q_s   [CW+1][2];
	logic [DW-1:0]  den_s [CW+1];
	logic [SBW-1:0] sb_s  [CW+1];
	logic [CW-1:0]  t_sn  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s[0] <= 1'b0;
			v_sn  <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s[0] <= v_s2;
			v_sn  <= v_s[CW];
		end
	end

	always_ff @(posedge clk) begin
		logic [CW-1:0] qq;
		if (en) begin
			neg_s1[0] <= num_lo[NW-1];
			neg_s1[1] <= num_hi[NW-1];
			mag_s1[0] <= num_lo[NW-1] ? NW'(-num_lo) : NW'(num_lo);
			mag_s1[1] <= num_hi[NW-1] ? NW'(-num_hi) : NW'(num_hi);
			den_s1    <= den;
			sb_s1     <= sb_in;

			den_s2 <= den_s1;
			sb_s2  <= sb_s1;
			for (int l = 0; l < 2; l++) begin
				neg_s2[l] <= neg_s1[l];
				// floor of a negative quotient: round the magnitude up
				dvd_s2[l] <= XW'(mag_s1[l])
					+ (neg_s1[l] ? (XW'(den_s1) - XW'(1)) : '0);
			end

			den_s[0] <= den_s2;
			sb_s[0]  <= sb_s2;
			for (int l = 0; l < 2; l++) begin
				neg_s[0][l] <= neg_s2[l];
				ovf_s[0][l] <= RWD'(dvd_s2[l]) >= (RWD'(den_s2) << CW);
				rem_s[0][l] <= RWD'(dvd_s2[l]);
				q_s[0][l]   <= '0;
			end

			sb_sn <= sb_s[CW];
			for (int l = 0; l < 2; l++) begin
				qq = q_s[CW][l];
				if (!neg_s[CW][l]) begin
					t_sn[l] <= (ovf_s[CW][l] | qq[CW-1]) ? MaxT : qq;
				end else begin
					t_sn[l] <= (ovf_s[CW][l] | (qq[CW-1] & |qq[CW-2:0]))
						? MinT : CW'(-qq);
				end
			end
		end
	end

	for (genvar j = 0; j < CW; j++) begin : g_stage
		localparam int K = CW - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1] <= den_s[j];
				sb_s[j+1]  <= sb_s[j];
				for (int l = 0; l < 2; l++) begin
					neg_s[j+1][l] <= neg_s[j][l];
					ovf_s[j+1][l] <= ovf_s[j][l];
					if (rem_s[j][l] >= (RWD'(den_s[j]) << K)) begin
						rem_s[j+1][l] <= rem_s[j][l] - (RWD'(den_s[j]) << K);
						q_s[j+1][l]   <= {q_s[j][l][CW-2:0], 1'b1};
					end else begin
						rem_s[j+1][l] <= rem_s[j][l];
						q_s[j+1][l]   <= {q_s[j][l][CW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = v_sn;
	assign t_lo      = $signed(t_sn[0]);
	assign t_hi      = $signed(t_sn[1]);
	assign sb_out    = sb_sn;

endmodule

// ===== rtl/core/mcst_checker.sv =====
// ----------------------------------------------------------------------------
// mcst_checker: port checks for the moving circle sweep test
// Watches handshakes and result words on the top level ports.
// ----------------------------------------------------------------------------
module mcst_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((2*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

	localparam int CW = COORD_WIDTH;

	logic signed [CW-1:0] tf, ts;

	assign tf = $signed(m_axis_tdata[CW:1]);
	assign ts = $signed(m_axis_tdata[2*CW:CW+1]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> tf == '0 && ts == '0)
		else $error("times not zero on a miss");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> tf <= ts)
		else $error("contact times out of order");

endmodule

bind moving_circle_sweep_test mcst_checker #(.COORD_WIDTH(COORD_WIDTH)) u_mcst_checker (.*);
